// ----- src/cfd_pkg.sv -----
// shared types and constants for the control frame deframer
// no dependencies
package cfd_pkg;

    localparam int CHANNELS_DEF = 32;
    localparam int RESULT_SLOTS = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0]  SYNC_A   = 8'hAA;
    localparam logic [7:0]  SYNC_B   = 8'h55;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  VERSION_RST = 8'd1;

    localparam int POS_SYNC_A  = 0;
    localparam int POS_SYNC_B  = 1;
    localparam int POS_VERSION = 2;
    localparam int POS_LEN_LO  = 6;
    localparam int POS_LEN_HI  = 7;
    localparam int HEADER_BYTES = 8;
    localparam int MIN_BYTES    = 2;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_VERSION = 3'd2,
        ST_LENGTH  = 3'd3,
        ST_CRC     = 3'd4
    } t_status_e;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SHOW
    } t_back_state_e;

endpackage

// ----- src/cfd_queue.sv -----
// short command queue between the byte front end and the result back end
// depends on cfd_pkg
module cfd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cfd_pkg::t_status_e  i_push_status,
    input  logic                i_pop,
    output logic                o_valid,
    output cfd_pkg::t_status_e  o_status,
    output logic                o_full
);
    import cfd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_status_e        r_data [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] res;
        if (p == PW'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PW'(1);
        end
        return res;
    endfunction

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ptr_inc(r_wr_ptr);
        end
        if (i_pop) begin
            n_rd_ptr = ptr_inc(r_rd_ptr);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_push_status;
        end
    end

    assign o_valid  = (r_count != '0);
    assign o_full   = (r_count == CW'(QUEUE_DEPTH));
    assign o_status = r_data[r_rd_ptr];

endmodule

// ----- src/cfd_front.sv -----
// byte front end: sync, header checks, crc16, channel capture, chunk classification
// depends on cfd_pkg
module cfd_front #(
    parameter int CHANNELS = cfd_pkg::CHANNELS_DEF,
    parameter int AW       = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_chunk_end,
    input  logic [7:0]          i_expected_version,
    input  logic                i_store_busy,
    input  logic                i_queue_full,
    output logic                o_push,
    output cfd_pkg::t_status_e  o_push_status,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [15:0]         o_wr_data
);
    import cfd_pkg::*;

    localparam int PAYLOAD_BYTES = 2 * CHANNELS;
    localparam int FRAME_BYTES   = HEADER_BYTES + PAYLOAD_BYTES + 2;
    localparam int BW            = $clog2(FRAME_BYTES + 1);

    localparam logic [BW-1:0] P_SYNC_A  = BW'(POS_SYNC_A);
    localparam logic [BW-1:0] P_SYNC_B  = BW'(POS_SYNC_B);
    localparam logic [BW-1:0] P_VERSION = BW'(POS_VERSION);
    localparam logic [BW-1:0] P_LEN_LO  = BW'(POS_LEN_LO);
    localparam logic [BW-1:0] P_LEN_HI  = BW'(POS_LEN_HI);
    localparam logic [BW-1:0] P_HEADER  = BW'(HEADER_BYTES);
    localparam logic [BW-1:0] P_CRC_LO  = BW'(HEADER_BYTES + PAYLOAD_BYTES);
    localparam logic [BW-1:0] P_CRC_HI  = BW'(HEADER_BYTES + PAYLOAD_BYTES + 1);
    localparam logic [BW-1:0] P_FRAME   = BW'(FRAME_BYTES);
    localparam logic [BW-1:0] P_MIN     = BW'(MIN_BYTES);
    localparam logic [15:0]   LEN_EXP   = 16'(PAYLOAD_BYTES);

    logic [BW-1:0] r_count,  n_count;
    logic          r_sync,   n_sync;
    logic          r_ver_ok, n_ver_ok;
    logic [15:0]   r_length, n_length;
    logic [15:0]   r_crc,    n_crc;
    logic [15:0]   r_rx_crc, n_rx_crc;
    logic [7:0]    r_hold,   n_hold;

    logic          accept;
    logic          in_payload;
    logic [BW-1:0] offset;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign in_payload = (r_count >= P_HEADER) && (r_count < P_CRC_LO);
    assign offset     = r_count - P_HEADER;
    assign o_ready    = !i_queue_full && !(i_store_busy && in_payload);
    assign accept     = i_valid && o_ready;

    assign o_wr_en   = accept && in_payload && offset[0];
    assign o_wr_addr = AW'(offset >> 1);
    assign o_wr_data = {i_data_byte, r_hold};

    always_comb begin
        n_count       = r_count;
        n_sync        = r_sync;
        n_ver_ok      = r_ver_ok;
        n_length      = r_length;
        n_crc         = r_crc;
        n_rx_crc      = r_rx_crc;
        n_hold        = r_hold;
        o_push        = 1'b0;
        o_push_status = ST_OK;
        if (accept) begin
            if (r_count < P_FRAME) begin
                if (r_count == P_SYNC_A) begin
                    n_sync = (i_data_byte == SYNC_A);
                end else if (r_count == P_SYNC_B) begin
                    n_sync = r_sync && (i_data_byte == SYNC_B);
                end else if (r_count == P_VERSION) begin
                    n_ver_ok = (i_data_byte == i_expected_version);
                end else if (r_count == P_LEN_LO) begin
                    n_hold = i_data_byte;
                end else if (r_count == P_LEN_HI) begin
                    n_length = {i_data_byte, r_hold};
                end else if (in_payload) begin
                    if (!offset[0]) begin
                        n_hold = i_data_byte;
                    end
                end else if (r_count == P_CRC_LO) begin
                    n_hold = i_data_byte;
                end else if (r_count == P_CRC_HI) begin
                    n_rx_crc = {i_data_byte, r_hold};
                end
                if (r_count < P_CRC_LO) begin
                    n_crc = crc_byte(r_crc, i_data_byte);
                end
                n_count = r_count + BW'(1);
            end
            if (i_chunk_end) begin
                if ((n_count >= P_MIN) && n_sync) begin
                    o_push = 1'b1;
                    if (n_count < P_FRAME) begin
                        o_push_status = ST_SHORT;
                    end else if (!n_ver_ok) begin
                        o_push_status = ST_VERSION;
                    end else if (n_length != LEN_EXP) begin
                        o_push_status = ST_LENGTH;
                    end else if (n_rx_crc != n_crc) begin
                        o_push_status = ST_CRC;
                    end else begin
                        o_push_status = ST_OK;
                    end
                end
                n_count  = '0;
                n_sync   = 1'b0;
                n_ver_ok = 1'b0;
                n_length = '0;
                n_crc    = CRC_INIT;
                n_rx_crc = '0;
                n_hold   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sync   <= 1'b0;
            r_ver_ok <= 1'b0;
            r_length <= '0;
            r_crc    <= CRC_INIT;
            r_rx_crc <= '0;
            r_hold   <= '0;
        end else begin
            r_count  <= n_count;
            r_sync   <= n_sync;
            r_ver_ok <= n_ver_ok;
            r_length <= n_length;
            r_crc    <= n_crc;
            r_rx_crc <= n_rx_crc;
            r_hold   <= n_hold;
        end
    end

endmodule

// ----- src/cfd_back.sv -----
// result back end: channel store and result sequencer with output register
// depends on cfd_pkg
module cfd_back #(
    parameter int CHANNELS = cfd_pkg::CHANNELS_DEF,
    parameter int AW       = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [15:0]         i_wr_data,
    input  logic                i_cmd_valid,
    input  cfd_pkg::t_status_e  i_cmd_status,
    output logic                o_cmd_pop,
    output logic                o_busy,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [4:0]          o_channel_index,
    output logic signed [15:0]  o_channel_value,
    output logic                o_last
);
    import cfd_pkg::*;

    localparam int NRES = (CHANNELS < RESULT_SLOTS) ? CHANNELS : RESULT_SLOTS;
    localparam logic [4:0] IDX_LAST = 5'(NRES - 1);

    logic [15:0]   r_mem [CHANNELS];
    logic [15:0]   r_rd_data;
    t_back_state_e r_state, n_state;
    logic [4:0]    r_idx;
    logic          r_err;
    t_status_e     r_status;
    logic          done;

    assign done = r_err || (r_idx == IDX_LAST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd_status == ST_OK) ? BK_READ : BK_SHOW;
                end
            end
            BK_READ: begin
                n_state = BK_SHOW;
            end
            BK_SHOW: begin
                if (i_ready) begin
                    n_state = done ? BK_IDLE : BK_READ;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        o_valid   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            BK_READ: begin
                o_valid = 1'b0;
            end
            BK_SHOW: begin
                o_valid = 1'b1;
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_idx    <= '0;
            r_err    <= (i_cmd_status != ST_OK);
            r_status <= i_cmd_status;
        end else if ((r_state == BK_SHOW) && i_ready && !done) begin
            r_idx <= r_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (r_state == BK_READ) begin
            r_rd_data <= r_mem[AW'(r_idx)];
        end
    end

    assign o_busy          = (r_state != BK_IDLE);
    assign o_status        = r_err ? r_status : ST_OK;
    assign o_channel_index = r_err ? 5'd0 : r_idx;
    assign o_channel_value = r_err ? 16'sd0 : $signed(r_rd_data);
    assign o_last          = done;

endmodule

// ----- src/control_frame_deframer_crc16.sv -----
// control frame deframer top level: version register, front end, queue, back end
// depends on cfd_pkg, cfd_front, cfd_queue, cfd_back
//
// input channel: one byte per item (i_data_byte) with i_chunk_end on the last
// byte of a chunk, handshake i_valid / o_ready. a chunk opening with 0xAA 0x55
// is checked for version, payload length and crc16-ccitt and gives either one
// error result or one result per channel (up to 32), the final one with o_last.
// other chunks give nothing. output channel: o_valid / i_ready with o_status,
// o_channel_index, o_channel_value, o_last.
// bytes are taken one per cycle while o_ready is high. the status pushed at a
// chunk end is popped by the idle back end, which shows an error result directly
// but reads each channel result through a registered store read before it shows.
// a two-entry status queue sits between the byte front end and the result
// sequencer, so header bytes of the next chunk keep flowing during a burst;
// payload bytes wait while the store is still being read out.
// when the receiver stalls the result register holds; the input stalls only
// once the queue is full or as above. synchronous reset clears all chunk state
// and sets the expected version to 1; i_cfg_wr_en writes it.
module control_frame_deframer_crc16 #(
    parameter int CHANNELS = cfd_pkg::CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_chunk_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [4:0]         o_channel_index,
    output logic signed [15:0] o_channel_value,
    output logic               o_last
);
    import cfd_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [7:0]    r_expected_version;
    logic          q_full, q_valid, q_pop, push;
    t_status_e     push_status, q_status;
    logic          back_busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version <= VERSION_RST;
        end else if (i_cfg_wr_en) begin
            r_expected_version <= i_cfg_wr_data;
        end
    end

    cfd_front #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_chunk_end        (i_chunk_end),
        .i_expected_version (r_expected_version),
        .i_store_busy       (back_busy || q_valid),
        .i_queue_full       (q_full),
        .o_push             (push),
        .o_push_status      (push_status),
        .o_wr_en            (wr_en),
        .o_wr_addr          (wr_addr),
        .o_wr_data          (wr_data)
    );

    cfd_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_push_status (push_status),
        .i_pop         (q_pop),
        .o_valid       (q_valid),
        .o_status      (q_status),
        .o_full        (q_full)
    );

    cfd_back #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_en         (wr_en),
        .i_wr_addr       (wr_addr),
        .i_wr_data       (wr_data),
        .i_cmd_valid     (q_valid),
        .i_cmd_status    (q_status),
        .o_cmd_pop       (q_pop),
        .o_busy          (back_busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last          (o_last)
    );

endmodule
